// ===== rtl/graph_curvature_eval_core_assert.svh =====
// Assertion macros for the curvature evaluation core.
`ifndef GRAPH_CURVATURE_EVAL_CORE_ASSERT_SVH
`define GRAPH_CURVATURE_EVAL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define GCE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define GCE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gce_pkg.sv =====
`default_nettype none

package gce_pkg;

    localparam int DATA_W     = 32;
    localparam int MAX_TERMS  = 4;
    localparam int COEF_IDX_W = 2;
    localparam int CFG_IDX_W  = 4;

    // Register map: slope coefficients, then bend coefficients
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEND_BASE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_END    = 4'd8;

    typedef logic signed [DATA_W-1:0] t_coef;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     ovf;
    } t_sat;

    // Clamp a wide signed value to the 32-bit range
    function automatic t_sat sat32(input logic signed [2*DATA_W-1:0] v);
        t_sat res;
        if (v > 64'sd2147483647) begin
            res.value = 32'sh7fffffff;
            res.ovf   = 1'b1;
        end else if (v < -64'sd2147483648) begin
            res.value = 32'sh80000000;
            res.ovf   = 1'b1;
        end else begin
            res.value = v[DATA_W-1:0];
            res.ovf   = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gce_div.sv =====
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage, QB stages.
// The quotient must be known to fit QB bits.
module gce_div #(
    parameter int NW = 48,
    parameter int DW = 47,
    parameter int QB = 32,
    parameter int UW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [UW-1:0] i_user,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_vld,
    output logic [UW-1:0] o_user,
    output logic [QB-1:0] o_quo
);

    localparam int HW = NW - QB;

    logic [DW-1:0] a_rem  [QB];
    logic [DW-1:0] a_den  [QB];
    logic [QB-1:0] a_w    [QB+1];
    logic          a_vld  [QB+1];
    logic [UW-1:0] a_user [QB+1];

    // Upper numerator bits start the remainder, lower bits feed the stages
    assign a_rem[0]  = {{(DW-HW){1'b0}}, i_num[NW-1:QB]};
    assign a_den[0]  = i_den;
    assign a_w[0]    = i_num[QB-1:0];
    assign a_vld[0]  = i_vld;
    assign a_user[0] = i_user;

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [QB-1:0] r_w;
        logic          r_vld;
        logic [UW-1:0] r_user;

        // Shift in the next numerator bit and try the subtraction
        always_comb begin
            w_trial = {a_rem[s], a_w[s][QB-1]};
            w_diff  = w_trial - {1'b0, a_den[s]};
            w_ge    = (w_trial >= {1'b0, a_den[s]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= a_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w    <= {a_w[s][QB-2:0], w_ge};
                r_user <= a_user[s];
            end
        end

        assign a_w[s+1]    = r_w;
        assign a_vld[s+1]  = r_vld;
        assign a_user[s+1] = r_user;

        // Remainder and divisor are only carried to stages that follow
        if (s < QB - 1) begin : g_carry
            logic [DW-1:0] r_rem;
            logic [DW-1:0] r_den;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                    r_den <= a_den[s];
                end
            end

            assign a_rem[s+1] = r_rem;
            assign a_den[s+1] = r_den;
        end
    end

    assign o_vld  = a_vld[QB];
    assign o_user = a_user[QB];
    assign o_quo  = a_w[QB];

endmodule

`default_nettype wire

// ===== rtl/graph_curvature_eval_core.sv =====
// Channel  | Dir | Signals                         | Content
// -------- | --- | ------------------------------- | ------------------------------------
// s_axis   | in  | i_s_tvalid/o_s_tready/i_s_tdata | sample_x
// m_axis   | out | o_m_tvalid/i_m_tready/o_m_tdata | curvature_value, saturated in tuser
// cfg      | in  | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One sample enters per cycle unless the output register is full and not taken.
// The depth is set by the 32-stage square root in parallel with the first divider,
// then the 32-stage second divider, one quotient or root bit per stage.
// Reset is synchronous, active low; it clears valid bits and the coefficients.
// The whole pipeline holds when the output register is full and not taken.
`default_nettype none

`include "graph_curvature_eval_core_assert.svh"

module graph_curvature_eval_core #(
    parameter int TERMS     = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [gce_pkg::DATA_W-1:0]       i_s_tdata,   // [31:0] sample_x
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [gce_pkg::DATA_W-1:0]       o_m_tdata,   // [30:0] curvature_value, [31] zero
    output logic [0:0]                       o_m_tuser,   // [0] saturated
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gce_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gce_pkg::DATA_W-1:0]       i_cfg_data
);

    import gce_pkg::*;

    localparam int PW  = 2 * DATA_W;
    localparam int DW  = PW - 1 - FRAC_BITS;
    localparam int RB  = DATA_W;
    localparam int RMW = DATA_W + 4;
    localparam logic signed [PW-1:0] HALF_S = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0]        HALF_U = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0]        ONE_U  = PW'(1) << FRAC_BITS;

    logic  w_en;
    t_coef r_slope_c [MAX_TERMS];
    t_coef r_bend_c  [MAX_TERMS];

    // Advance everything unless a finished result is waiting and not taken
    assign w_en        = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Coefficient registers; indexes past the bend block are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TERMS; i++) begin
                r_slope_c[i] <= '0;
                r_bend_c[i]  <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index < CFG_BEND_BASE) begin
                r_slope_c[i_cfg_index[COEF_IDX_W-1:0]] <= i_cfg_data;
            end else if (i_cfg_index < CFG_REG_END) begin
                r_bend_c[i_cfg_index[COEF_IDX_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // Input register
    logic                     r_v0;
    logic signed [DATA_W-1:0] r_x0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0 <= i_s_tdata;
        end
    end

    // Horner evaluation: a multiply stage and a round/add/clamp stage per term after the highest
    t_coef a_acc_s [TERMS];
    t_coef a_acc_q [TERMS];
    t_coef a_x     [TERMS];
    logic  a_v     [TERMS];
    logic  a_f     [TERMS];

    assign a_acc_s[0] = r_slope_c[TERMS-1];
    assign a_acc_q[0] = r_bend_c[TERMS-1];
    assign a_x[0]     = r_x0;
    assign a_v[0]     = r_v0;
    assign a_f[0]     = 1'b0;

    for (genvar j = 0; j < TERMS - 1; j++) begin : g_horner
        localparam int K = TERMS - 2 - j;
        logic signed [PW-1:0] r_ps;
        logic signed [PW-1:0] r_pq;
        t_coef                r_xm;
        logic                 r_vm;
        logic                 r_fm;
        t_coef                r_as;
        t_coef                r_aq;
        t_coef                r_xa;
        logic                 r_va;
        logic                 r_fa;
        logic signed [PW-1:0] w_sum_s;
        logic signed [PW-1:0] w_sum_q;
        t_sat                 w_sat_s;
        t_sat                 w_sat_q;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vm <= 1'b0;
                r_va <= 1'b0;
            end else if (w_en) begin
                r_vm <= a_v[j];
                r_va <= r_vm;
            end
        end

        // Product stage
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ps <= a_acc_s[j] * a_x[j];
                r_pq <= a_acc_q[j] * a_x[j];
                r_xm <= a_x[j];
                r_fm <= a_f[j];
            end
        end

        // Round half up, add the next coefficient, clamp
        always_comb begin
            w_sum_s = ((r_ps + HALF_S) >>> FRAC_BITS) + PW'(r_slope_c[K]);
            w_sum_q = ((r_pq + HALF_S) >>> FRAC_BITS) + PW'(r_bend_c[K]);
            w_sat_s = sat32(w_sum_s);
            w_sat_q = sat32(w_sum_q);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_as <= w_sat_s.value;
                r_aq <= w_sat_q.value;
                r_xa <= r_xm;
                r_fa <= r_fm | w_sat_s.ovf | w_sat_q.ovf;
            end
        end

        assign a_acc_s[j+1] = r_as;
        assign a_acc_q[j+1] = r_aq;
        assign a_x[j+1]     = r_xa;
        assign a_v[j+1]     = r_va;
        assign a_f[j+1]     = r_fa;
    end

    // Magnitudes, square of the slope, then the denominator 1 + s^2
    logic              r_vb, r_vc, r_vd;
    logic              r_fb, r_fc, r_fd;
    logic [DATA_W-1:0] r_smag, r_qmag_b, r_qmag_c, r_qmag_d;
    logic [PW-1:0]     r_sq;
    logic [DW-1:0]     r_d;
    logic [PW-1:0]     w_d_full;
    t_coef             w_s;
    t_coef             w_q;

    assign w_s      = a_acc_s[TERMS-1];
    assign w_q      = a_acc_q[TERMS-1];
    assign w_d_full = ONE_U + ((r_sq + HALF_U) >> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (w_en) begin
            r_vb <= a_v[TERMS-1];
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_smag   <= w_s[DATA_W-1] ? (~w_s + 1'b1) : w_s;
            r_qmag_b <= w_q[DATA_W-1] ? (~w_q + 1'b1) : w_q;
            r_fb     <= a_f[TERMS-1];
            r_sq     <= r_smag * r_smag;
            r_qmag_c <= r_qmag_b;
            r_fc     <= r_fb;
            r_d      <= w_d_full[DW-1:0];
            r_qmag_d <= r_qmag_c;
            r_fd     <= r_fc;
        end
    end

    // Square root of d scaled by one, two radicand bits per stage
    logic [PW-1:0]  a_rad  [RB];
    logic [RMW-1:0] a_rem  [RB+1];
    logic [RB-1:0]  a_root [RB+1];

    assign a_rad[0]  = {1'b0, r_d, {FRAC_BITS{1'b0}}};
    assign a_rem[0]  = '0;
    assign a_root[0] = '0;

    for (genvar i = 0; i < RB; i++) begin : g_sqrt
        logic [RMW-1:0] w_rem2;
        logic [RMW-1:0] w_trial;
        logic           w_ge;
        logic [RMW-1:0] r_rem;
        logic [RB-1:0]  r_root;

        always_comb begin
            w_rem2  = {a_rem[i][RMW-3:0], a_rad[i][PW-1:PW-2]};
            w_trial = {{(RMW-RB-2){1'b0}}, a_root[i], 2'b01};
            w_ge    = (w_rem2 >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
                r_root <= {a_root[i][RB-2:0], w_ge};
            end
        end

        assign a_rem[i+1]  = r_rem;
        assign a_root[i+1] = r_root;

        if (i < RB - 1) begin : g_rad
            logic [PW-1:0] r_rad;

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rad <= a_rad[i] << 2;
                end
            end

            assign a_rad[i+1] = r_rad;
        end
    end

    // t = |q| * one / d, alongside the root
    logic              w_vt;
    logic [0:0]        w_ft;
    logic [DATA_W-1:0] w_t;
    logic [RB-1:0]     w_r;

    assign w_r = a_root[RB];

    gce_div #(
        .NW (DATA_W + FRAC_BITS),
        .DW (DW),
        .QB (DATA_W),
        .UW (1)
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vd),
        .i_user  (r_fd),
        .i_num   ({r_qmag_d, {FRAC_BITS{1'b0}}}),
        .i_den   (r_d),
        .o_vld   (w_vt),
        .o_user  (w_ft),
        .o_quo   (w_t)
    );

    // k = t * one / root
    logic              w_vk;
    logic [0:0]        w_fk;
    logic [DATA_W-1:0] w_k;

    gce_div #(
        .NW (DATA_W + FRAC_BITS),
        .DW (RB),
        .QB (DATA_W),
        .UW (1)
    ) u_div_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vt),
        .i_user  (w_ft),
        .i_num   ({w_t, {FRAC_BITS{1'b0}}}),
        .i_den   (w_r),
        .o_vld   (w_vk),
        .o_user  (w_fk),
        .o_quo   (w_k)
    );

    // Output register: clamp the curvature and merge the flags
    logic                r_ov;
    logic [DATA_W-2:0]   r_curv;
    logic                r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_vk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_curv <= w_k[DATA_W-1] ? '1 : w_k[DATA_W-2:0];
            r_sat  <= w_fk[0] | w_k[DATA_W-1];
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {1'b0, r_curv};
    assign o_m_tuser  = r_sat;

    // Checks
    `GCE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_d) && $stable(r_vd), "pipeline moved while stalled")
    `GCE_ASSERT_IMPL(a_root_floor, i_clk, i_rst_n, w_vt, |w_r[RB-1:FRAC_BITS], "square root below one")
    `GCE_ASSERT_IMPL(a_t_range, i_clk, i_rst_n, w_vt, !(w_t[DATA_W-1] && |w_t[DATA_W-2:0]), "first quotient out of range")

endmodule

`default_nettype wire

// ===== verif/tb_graph_curvature_eval_core.sv =====
`default_nettype none

module tb_graph_curvature_eval_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gce_pkg::*;

    localparam int TERMS     = 4;
    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = 2 * TERMS + 67;

    typedef struct packed {
        logic [30:0] curv;
        logic        sat;
    } t_curv_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [DATA_W-1:0]    i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [DATA_W-1:0]    o_m_tdata;
    logic [0:0]           o_m_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    // coefficient shadow and expected curvature queue
    logic signed [63:0] slope_coef [MAX_TERMS];
    logic signed [63:0] bend_coef [MAX_TERMS];
    t_curv_res          curv_expected [$];
    int                 fail_count;
    bit                 idle_on;

    graph_curvature_eval_core #(.TERMS(TERMS), .FRAC_BITS(FRAC_BITS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor division by 2^FRAC_BITS after adding half
    function automatic logic signed [63:0] round_q(input logic signed [127:0] p);
        logic signed [127:0] v;
        v = (p + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                   inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] horner(input logic signed [63:0] c [MAX_TERMS],
                                                  input logic signed [63:0] x,
                                                  inout bit flag);
        logic signed [63:0] acc;
        acc = c[TERMS-1];
        for (int k = TERMS - 2; k >= 0; k--)
            acc = clamp32(round_q(128'(acc) * 128'(x)) + c[k], flag);
        return acc;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        root = 0;
        for (int b = 31; b >= 0; b--)
            if (128'(root | (64'd1 << b)) * 128'(root | (64'd1 << b)) <= 128'(n))
                root = root | (64'd1 << b);
        return root;
    endfunction

    function automatic t_curv_res curvature_of(input logic [31:0] xin);
        t_curv_res          res;
        bit                 flag;
        logic signed [63:0] x, s, q;
        logic [63:0]        s_mag, q_mag, d, r, t, k;
        flag  = 1'b0;
        x     = 64'(signed'(xin));
        s     = horner(slope_coef, x, flag);
        q     = horner(bend_coef, x, flag);
        s_mag = s < 0 ? -s : s;
        q_mag = q < 0 ? -q : q;
        d     = (64'd1 << FRAC_BITS) + ((s_mag * s_mag + (64'd1 << (FRAC_BITS - 1)))
                >> FRAC_BITS);
        r     = int_sqrt(d << FRAC_BITS);
        t     = (q_mag << FRAC_BITS) / d;
        k     = (t << FRAC_BITS) / r;
        if (k > 64'd2147483647) begin
            k    = 64'd2147483647;
            flag = 1'b1;
        end
        res.curv = k[30:0];
        res.sat  = flag;
        return res;
    endfunction

    task automatic idle_burst();
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
    endtask

    // send one sample, hold until transfer
    task automatic send_sample(input logic [31:0] x);
        idle_burst();
        i_s_tvalid = 1'b1;
        i_s_tdata  = x;
        curv_expected.push_back(curvature_of(x));
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx < CFG_BEND_BASE)
            slope_coef[idx] = 64'(signed'(val));
        else if (idx < CFG_REG_END)
            bend_coef[idx - CFG_BEND_BASE] = 64'(signed'(val));
    endtask

    task automatic drain();
        while (curv_expected.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
            2: return 32'h7fffffff;
            3: return 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h1fff)) - 32'sh1000);
        endcase
    endfunction

    function automatic logic [31:0] rand_x();
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h5ffff)) - 32'sh2ffff);
        endcase
    endfunction

    task automatic test_reset_coefs();
        send_sample(32'h0);
        send_sample(32'h7fffffff);
        send_sample(32'h80000000);
        drain();
    endtask

    task automatic test_directed();
        // q = -2^31 flat slope: result overflow
        write_reg(CFG_BEND_BASE, 32'h80000000);
        send_sample(32'h0);
        drain();
        // q = 1.0 flat: curvature one
        write_reg(CFG_BEND_BASE, 32'h00010000);
        send_sample(32'h00010000);
        drain();
        // steep slope, cubic bend overflowing in Horner
        write_reg(CFG_SLOPE_BASE, 32'h7fffffff);
        write_reg(CFG_SLOPE_BASE + 4'd1, 32'h80000000);
        write_reg(CFG_SLOPE_BASE + 4'd2, 32'h00020000);
        write_reg(CFG_SLOPE_BASE + 4'd3, 32'hffff0000);
        write_reg(CFG_BEND_BASE + 4'd1, 32'h7fffffff);
        write_reg(CFG_BEND_BASE + 4'd2, 32'h80000000);
        write_reg(CFG_BEND_BASE + 4'd3, 32'h00008000);
        // unknown indexes do nothing
        for (int i = 8; i < 16; i++) write_reg(CFG_IDX_W'(i), 32'hdeadbeef);
        send_sample(32'h0);
        send_sample(32'h7fffffff);
        send_sample(32'h80000000);
        send_sample(32'hffffffff);
        send_sample(32'h00000001);
        send_sample(32'h00008000);
        send_sample(32'hffff8000);
        send_sample(32'h55555555);
        send_sample(32'haaaaaaaa);
        drain();
    endtask

    task automatic test_random(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            for (int i = 0; i < 2 * MAX_TERMS; i++)
                if ($urandom_range(0, 2) != 0) write_reg(CFG_IDX_W'(i), rand_coef());
            for (int n = 0; n < per_phase; n++) send_sample(rand_x());
            drain();
        end
    endtask

    // check each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_curv_res exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (curv_expected.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time, o_m_tdata,
                         o_m_tuser);
                fail_count++;
            end else begin
                exp_res = curv_expected.pop_front();
                if (o_m_tdata !== {1'b0, exp_res.curv} || o_m_tuser[0] !== exp_res.sat) begin
                    $display("%0t: mismatch expected curv=%h sat=%b actual tdata=%h sat=%b",
                             $time, exp_res.curv, exp_res.sat, o_m_tdata, o_m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // random sink stalls
    initial begin
        i_m_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_m_tready = 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("graph_curvature_eval_core verification failed");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        fail_count  = 0;
        idle_on     = 1'b1;
        for (int i = 0; i < MAX_TERMS; i++) begin
            slope_coef[i] = 0;
            bend_coef[i]  = 0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_reset_coefs();
        test_directed();
        test_random(30, 50);
        idle_on = 1'b0;
        test_random(8, 50);
        if (fail_count == 0)
            $display("graph_curvature_eval_core verification clean");
        else
            $display("graph_curvature_eval_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== graph_curvature_eval_core.f =====
+incdir+rtl
rtl/gce_pkg.sv
rtl/gce_div.sv
rtl/graph_curvature_eval_core.sv
verif/tb_graph_curvature_eval_core.sv
